### hw/rtl/rtp_pkg.sv
// shared types, constants and helpers of the radial/tangential point projector
package rtp_pkg;

   localparam int unsigned DIV_STEPS = 64;

   localparam logic signed [63:0] FRAC_ONE   = 64'sh0000_0001_0000_0000;
   localparam logic signed [63:0] Q64_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q64_MIN    = 64'sh8000_0000_0000_0000;
   localparam logic signed [31:0] K1_MIN_RAW = 32'sd108;

   typedef enum logic [7:0] {
      REG_FOCAL_X  = 8'd0,
      REG_FOCAL_Y  = 8'd1,
      REG_CENTER_X = 8'd2,
      REG_CENTER_Y = 8'd3,
      REG_RAD_K1   = 8'd4,
      REG_RAD_K2   = 8'd5,
      REG_TAN_P1   = 8'd6,
      REG_TAN_P2   = 8'd7
   } rtp_reg_type;

   typedef struct packed {
      logic valid;
      logic zero;
      logic u_pos;
      logic v_pos;
   } rtp_tag_type;

   // sign and magnitude back to a saturated signed 64-bit value
   function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
      if (neg) begin
         return m[63] ? Q64_MIN : -$signed(m);
      end
      return m[63] ? Q64_MAX : $signed(m);
   endfunction

endpackage

### hw/rtl/radial_tangential_point_projector_top.sv
// top level of the pinhole projector with radial and tangential lens distortion
//
// a point (req_pt_x, req_pt_y, req_pt_z, signed Q16.16) is taken at each rising edge
// with start high; busy is always low, so a new point can be given every cycle.
// each point gives exactly one result: rsp_pix_u, rsp_pix_v (Q16.16, saturated) and
// rsp_zero_depth, shown for one cycle with rsp_valid high. the receiver cannot stall.
// each result passes through the 64-stage divider with its input and output registers,
// then five chained four-stage multiplies, the saturating adds between them and the
// output register. throughput is one point per cycle, in order.
// the csr_ channel writes the eight registers (index 0..7: focal_x, focal_y,
// center_x, center_y, k1, k2, p1, p2); csr_ready is always high and writes with
// other indexes are dropped. write registers only while no point is in flight.
// reset (synchronous) loads the register reset values and clears all valid bits;
// nothing is emitted for points in flight at reset.
module radial_tangential_point_projector_top import rtp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pt_x,
   input  logic signed [31:0] req_pt_y,
   input  logic signed [31:0] req_pt_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_pix_u,
   output logic signed [31:0] rsp_pix_v,
   output logic               rsp_zero_depth,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic [30:0]        focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic signed [31:0] k1_ff, k2_ff, p1_ff, p2_ff;

   rtp_tag_type        in_tag;
   rtp_tag_type        tag0;
   logic signed [63:0] x0, y0;

   logic signed [63:0] k1s, k2s, p1s, p2s, fx64, fy64;
   logic               distort_en;

   logic signed [63:0] xx_p, yy_p, xy_p;
   logic signed [63:0] kr_p, p1a1_p, p2a2_p, p1a3_p, p2a1_p;
   logic signed [63:0] rs_p, xr_p, yr_p, fu_p, fv_p;

   logic signed [63:0] x_dl_ff  [1:22];
   logic signed [63:0] y_dl_ff  [1:22];
   logic signed [63:0] r2_dl_ff [5:11];
   logic signed [63:0] a1_5_ff, x2d_5_ff, y2d_5_ff;
   logic signed [63:0] a1_6_ff, a2_6_ff, a3_6_ff;
   logic signed [63:0] s_11_ff, rd_16_ff;
   logic signed [63:0] p1a1_dl_ff [11:20];
   logic signed [63:0] p1a3_dl_ff [11:20];
   logic signed [63:0] p2a2_dl_ff [11:21];
   logic signed [63:0] p2a1_dl_ff [11:21];
   logic signed [63:0] ex_ff, ey_ff, dx_ff, dy_ff;
   logic signed [63:0] nx_in, ny_in;
   rtp_tag_type        tag_dl_ff [1:26];

   logic               rsp_valid_ff, rsp_zero_ff;
   logic signed [31:0] rsp_pix_u_ff, rsp_pix_v_ff;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? Q64_MIN : Q64_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v[63:31] == 33'd0 || v[63:31] == {33{1'b1}}) begin
         return v[31:0];
      end
      return v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 31'd65536;
         focal_y_ff  <= 31'd65536;
         center_x_ff <= '0;
         center_y_ff <= '0;
         k1_ff       <= '0;
         k2_ff       <= '0;
         p1_ff       <= '0;
         p2_ff       <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FOCAL_X:  focal_x_ff  <= csr_data[30:0];
            REG_FOCAL_Y:  focal_y_ff  <= csr_data[30:0];
            REG_CENTER_X: center_x_ff <= csr_data[30:0];
            REG_CENTER_Y: center_y_ff <= csr_data[30:0];
            REG_RAD_K1:   k1_ff       <= csr_data;
            REG_RAD_K2:   k2_ff       <= csr_data;
            REG_TAN_P1:   p1_ff       <= csr_data;
            REG_TAN_P2:   p2_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // Q2.30 coefficients to Q31.32
   assign k1s  = {{30{k1_ff[31]}}, k1_ff, 2'b00};
   assign k2s  = {{30{k2_ff[31]}}, k2_ff, 2'b00};
   assign p1s  = {{30{p1_ff[31]}}, p1_ff, 2'b00};
   assign p2s  = {{30{p2_ff[31]}}, p2_ff, 2'b00};
   assign fx64 = {33'd0, focal_x_ff};
   assign fy64 = {33'd0, focal_y_ff};
   assign distort_en = (k1_ff >= K1_MIN_RAW) || (k1_ff <= -K1_MIN_RAW);

   assign in_tag = '{valid: start, zero: (req_pt_z == 32'sd0),
                     u_pos: ~req_pt_x[31], v_pos: ~req_pt_y[31]};

   rtp_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (in_tag),
      .num_x   (req_pt_x),
      .num_y   (req_pt_y),
      .den     (req_pt_z),
      .out_tag (tag0),
      .quo_x   (x0),
      .quo_y   (y0)
   );

   // products; the pipeline registers below are named by the step at which their value appears
   rtp_mulq u_mul_xx   (.clock(clock), .a(x0),           .b(x0),           .p(xx_p));
   rtp_mulq u_mul_yy   (.clock(clock), .a(y0),           .b(y0),           .p(yy_p));
   rtp_mulq u_mul_xy   (.clock(clock), .a(x0),           .b(y0),           .p(xy_p));
   rtp_mulq u_mul_kr   (.clock(clock), .a(k2s),          .b(r2_dl_ff[6]),  .p(kr_p));
   rtp_mulq u_mul_p1a1 (.clock(clock), .a(p1s),          .b(a1_6_ff),      .p(p1a1_p));
   rtp_mulq u_mul_p2a2 (.clock(clock), .a(p2s),          .b(a2_6_ff),      .p(p2a2_p));
   rtp_mulq u_mul_p1a3 (.clock(clock), .a(p1s),          .b(a3_6_ff),      .p(p1a3_p));
   rtp_mulq u_mul_p2a1 (.clock(clock), .a(p2s),          .b(a1_6_ff),      .p(p2a1_p));
   rtp_mulq u_mul_rs   (.clock(clock), .a(r2_dl_ff[11]), .b(s_11_ff),      .p(rs_p));
   rtp_mulq u_mul_xr   (.clock(clock), .a(x_dl_ff[16]),  .b(rd_16_ff),     .p(xr_p));
   rtp_mulq u_mul_yr   (.clock(clock), .a(y_dl_ff[16]),  .b(rd_16_ff),     .p(yr_p));
   rtp_mulq u_mul_fu   (.clock(clock), .a(fx64),         .b(nx_in),        .p(fu_p));
   rtp_mulq u_mul_fv   (.clock(clock), .a(fy64),         .b(ny_in),        .p(fv_p));

   assign nx_in = distort_en ? dx_ff : x_dl_ff[22];
   assign ny_in = distort_en ? dy_ff : y_dl_ff[22];

   always_ff @(posedge clock) begin
      x_dl_ff[1] <= x0;
      y_dl_ff[1] <= y0;
      for (int i = 2; i <= 22; i++) begin
         x_dl_ff[i] <= x_dl_ff[i-1];
         y_dl_ff[i] <= y_dl_ff[i-1];
      end

      r2_dl_ff[5] <= sat_add(xx_p, yy_p);
      for (int i = 6; i <= 11; i++) begin
         r2_dl_ff[i] <= r2_dl_ff[i-1];
      end
      a1_5_ff  <= sat_add(xy_p, xy_p);
      x2d_5_ff <= sat_add(xx_p, xx_p);
      y2d_5_ff <= sat_add(yy_p, yy_p);

      a1_6_ff <= a1_5_ff;
      a2_6_ff <= sat_add(r2_dl_ff[5], x2d_5_ff);
      a3_6_ff <= sat_add(r2_dl_ff[5], y2d_5_ff);

      s_11_ff  <= sat_add(k1s, kr_p);
      rd_16_ff <= sat_add(FRAC_ONE, rs_p);

      p1a1_dl_ff[11] <= p1a1_p;
      p1a3_dl_ff[11] <= p1a3_p;
      p2a2_dl_ff[11] <= p2a2_p;
      p2a1_dl_ff[11] <= p2a1_p;
      for (int i = 12; i <= 20; i++) begin
         p1a1_dl_ff[i] <= p1a1_dl_ff[i-1];
         p1a3_dl_ff[i] <= p1a3_dl_ff[i-1];
      end
      for (int i = 12; i <= 21; i++) begin
         p2a2_dl_ff[i] <= p2a2_dl_ff[i-1];
         p2a1_dl_ff[i] <= p2a1_dl_ff[i-1];
      end

      // saturating sums in the same order as the polynomial is written
      ex_ff <= sat_add(xr_p, p1a1_dl_ff[20]);
      ey_ff <= sat_add(yr_p, p1a3_dl_ff[20]);
      dx_ff <= sat_add(ex_ff, p2a2_dl_ff[21]);
      dy_ff <= sat_add(ey_ff, p2a1_dl_ff[21]);

      if (tag_dl_ff[26].zero) begin
         rsp_pix_u_ff <= tag_dl_ff[26].u_pos ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         rsp_pix_v_ff <= tag_dl_ff[26].v_pos ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end else begin
         rsp_pix_u_ff <= sat32(sat_add(fu_p, {33'd0, center_x_ff}));
         rsp_pix_v_ff <= sat32(sat_add(fv_p, {33'd0, center_y_ff}));
      end
      rsp_zero_ff <= tag_dl_ff[26].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 26; i++) begin
            tag_dl_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         tag_dl_ff[1] <= tag0;
         for (int i = 2; i <= 26; i++) begin
            tag_dl_ff[i] <= tag_dl_ff[i-1];
         end
         rsp_valid_ff <= tag_dl_ff[26].valid;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pix_u      = rsp_pix_u_ff;
   assign rsp_pix_v      = rsp_pix_v_ff;
   assign rsp_zero_depth = rsp_zero_ff;

endmodule

### hw/rtl/rtp_divider.sv
// pipelined restoring divider: x/z and y/z to signed Q31.32, one quotient bit a stage
module rtp_divider import rtp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  rtp_tag_type        in_tag,
   input  logic signed [31:0] num_x,
   input  logic signed [31:0] num_y,
   input  logic signed [31:0] den,
   output rtp_tag_type        out_tag,
   output logic signed [63:0] quo_x,
   output logic signed [63:0] quo_y
);

   localparam int unsigned STEPS = DIV_STEPS;

   logic [31:0] rem_x_ff  [0:STEPS];
   logic [31:0] rem_y_ff  [0:STEPS];
   logic [63:0] work_x_ff [0:STEPS];
   logic [63:0] work_y_ff [0:STEPS];
   logic [31:0] den_ff    [0:STEPS];
   logic        neg_x_ff  [0:STEPS];
   logic        neg_y_ff  [0:STEPS];
   rtp_tag_type tag_ff    [0:STEPS];

   logic signed [63:0] quo_x_ff;
   logic signed [63:0] quo_y_ff;
   rtp_tag_type        out_tag_ff;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [95:0] div_step(input logic [31:0] rem, input logic [63:0] work,
                                            input logic [31:0] dv);
      logic [32:0] sh;
      logic [33:0] df;
      sh = {rem, work[63]};
      df = {1'b0, sh} - {2'b00, dv};
      if (df[33]) begin
         return {sh[31:0], work[62:0], 1'b0};
      end
      return {df[31:0], work[62:0], 1'b1};
   endfunction

   always_ff @(posedge clock) begin
      rem_x_ff[0]  <= '0;
      rem_y_ff[0]  <= '0;
      work_x_ff[0] <= {mag32(num_x), 32'd0};
      work_y_ff[0] <= {mag32(num_y), 32'd0};
      den_ff[0]    <= mag32(den);
      neg_x_ff[0]  <= num_x[31] ^ den[31];
      neg_y_ff[0]  <= num_y[31] ^ den[31];
      for (int i = 1; i <= STEPS; i++) begin
         {rem_x_ff[i], work_x_ff[i]} <= div_step(rem_x_ff[i-1], work_x_ff[i-1], den_ff[i-1]);
         {rem_y_ff[i], work_y_ff[i]} <= div_step(rem_y_ff[i-1], work_y_ff[i-1], den_ff[i-1]);
         den_ff[i]   <= den_ff[i-1];
         neg_x_ff[i] <= neg_x_ff[i-1];
         neg_y_ff[i] <= neg_y_ff[i-1];
      end
      quo_x_ff <= from_mag(neg_x_ff[STEPS], work_x_ff[STEPS]);
      quo_y_ff <= from_mag(neg_y_ff[STEPS], work_y_ff[STEPS]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STEPS; i++) begin
            tag_ff[i] <= '0;
         end
         out_tag_ff <= '0;
      end else begin
         tag_ff[0] <= in_tag;
         for (int i = 1; i <= STEPS; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         out_tag_ff <= tag_ff[STEPS];
      end
   end

   assign quo_x   = quo_x_ff;
   assign quo_y   = quo_y_ff;
   assign out_tag = out_tag_ff;

endmodule

### hw/rtl/rtp_mulq.sv
// four-stage Q31.32 multiplier: 32x32 partial products, round half away, saturate
module rtp_mulq import rtp_pkg::*; (
   input  logic               clock,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic signed [63:0] p
);

   logic        neg_a_ff, neg_b_ff, neg_c_ff;
   logic [63:0] ma_ff, mb_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [31:0] lo_ff;
   logic [2:0]  cy_ff;
   logic [63:0] p11_c_ff;
   logic [31:0] p01h_ff, p10h_ff;
   logic signed [63:0] p_ff;

   logic [64:0] rnd_in;
   logic [34:0] mid_in;
   logic [65:0] hi_in;

   always_comb begin
      rnd_in = {1'b0, p00_ff} + 65'h0_8000_0000;
      mid_in = {2'b00, rnd_in[64:32]} + {3'b000, p01_ff[31:0]} + {3'b000, p10_ff[31:0]};
      hi_in  = {2'b00, p11_c_ff} + {34'd0, p01h_ff} + {34'd0, p10h_ff} + {63'd0, cy_ff};
   end

   always_ff @(posedge clock) begin
      neg_a_ff <= a[63] ^ b[63];
      ma_ff    <= a[63] ? (~a + 64'd1) : a;
      mb_ff    <= b[63] ? (~b + 64'd1) : b;

      neg_b_ff <= neg_a_ff;
      p00_ff   <= ma_ff[31:0]  * mb_ff[31:0];
      p01_ff   <= ma_ff[31:0]  * mb_ff[63:32];
      p10_ff   <= ma_ff[63:32] * mb_ff[31:0];
      p11_ff   <= ma_ff[63:32] * mb_ff[63:32];

      neg_c_ff <= neg_b_ff;
      lo_ff    <= mid_in[31:0];
      cy_ff    <= mid_in[34:32];
      p11_c_ff <= p11_ff;
      p01h_ff  <= p01_ff[63:32];
      p10h_ff  <= p10_ff[63:32];

      if (hi_in[65:32] != 34'd0) begin
         p_ff <= neg_c_ff ? Q64_MIN : Q64_MAX;
      end else begin
         p_ff <= from_mag(neg_c_ff, {hi_in[31:0], lo_ff});
      end
   end

   assign p = p_ff;

endmodule
